@@ hw/rtl/lef_pkg.sv @@
`timescale 1ns / 1ps

package lef_pkg;

  // Sizes
  localparam int LINE_DEPTH_DEF  = 32;   // line store entries
  localparam int QUEUE_DEPTH_DEF = 2;    // command queue entries
  localparam int LIMIT_W         = 6;    // width of the line_limit register
  localparam int LEN_W           = 5;    // width of the reported line length
  localparam int IDX_W           = 6;    // covers any supported store depth
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  // Result kinds
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Echo actions carried in a command
  localparam logic [1:0] ECHO_NONE = 2'd0;
  localparam logic [1:0] ECHO_CHAR = 2'd1;
  localparam logic [1:0] ECHO_BS   = 2'd2;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // Register map
  localparam logic CFG_LINE_LIMIT = 1'b0;

  // One classified item handed from front to back
  typedef struct packed {
    logic [1:0]       echo;
    logic [7:0]       ch;
    logic [IDX_W-1:0] waddr;
    logic             end_line;
    logic [IDX_W-1:0] len;
  } cmd_t;

endpackage

@@ hw/rtl/line_editor_with_echo.sv @@
`timescale 1ns / 1ps

// Terminal line editor with echo.
// Input channel (in_valid / in_stall / in_rx_byte): one received byte per
// transfer. Result channel (out_valid / out_stall / out_*): echo bytes,
// completed line bytes and an end-of-line marker carrying the length;
// out_last marks the final result caused by one input byte.
// Configuration: APB-style port, line_limit at byte address 0.
// The front end classifies each byte in the cycle it is taken and queues a
// command; the back end turns commands into results, one per cycle while
// the receiver takes them, and pops the next command only after the last
// result of the current one. Between input transfer and first result sit
// the queue, the back end command register and the output register. The
// front end takes a new byte every cycle until the command queue fills
// (QUEUE_DEPTH entries). A stall on the result channel holds the output
// register; the back end and then the front end wait behind it. Bytes that
// give no result queue no command. Reset empties the queue, clears the fill
// count and sets line_limit to 32; the line store needs no clearing.
module line_editor_with_echo #(
  parameter int LINE_DEPTH  = lef_pkg::LINE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = lef_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_byte,
  output logic [lef_pkg::LEN_W-1:0] out_line_length,
  output logic                      out_last,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [2:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import lef_pkg::*;

  logic [LIMIT_W-1:0] line_limit_r;
  logic               cfg_wr;
  logic               q_full, q_push, q_pop, q_valid;
  cmd_t               push_cmd, pop_cmd;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == CFG_LINE_LIMIT);
  assign cfg_prdata = (cfg_paddr[2] == CFG_LINE_LIMIT) ?
                      {{(32 - LIMIT_W){1'b0}}, line_limit_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      line_limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  lef_front #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_limit (line_limit_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  lef_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (pop_cmd)
  );

  lef_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (pop_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

endmodule

@@ hw/rtl/lef_ram.sv @@
`timescale 1ns / 1ps

module lef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/lef_queue.sv @@
`timescale 1ns / 1ps

module lef_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lef_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output lef_pkg::cmd_t pop_data
);
  import lef_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("command queue underflow");

endmodule

@@ hw/rtl/lef_front.sv @@
`timescale 1ns / 1ps

module lef_front #(
  parameter int LINE_DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lef_pkg::LIMIT_W-1:0] line_limit,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        q_full,
  output logic                        q_push,
  output lef_pkg::cmd_t               q_cmd
);
  import lef_pkg::*;

  localparam int FW = $clog2(LINE_DEPTH);

  logic [FW-1:0]      fill_count_r, fill_count_nxt;
  logic [FW-1:0]      fill_after;
  logic [LIMIT_W-1:0] lim, cap, fill_ext, after_ext;
  logic               is_eol, is_bs, is_print, do_store, do_erase, end_line, in_fire;

  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  // Effective capacity from the limit register
  always_comb begin
    if (line_limit < LIMIT_W'(2)) begin
      lim = LIMIT_W'(2);
    end else if (line_limit > LIMIT_W'(LINE_DEPTH)) begin
      lim = LIMIT_W'(LINE_DEPTH);
    end else begin
      lim = line_limit;
    end
    cap = lim - 1'b1;
  end

  // Classify the byte
  assign is_eol   = (in_rx_byte == CH_CR) || (in_rx_byte == CH_LF);
  assign is_bs    = (in_rx_byte == CH_BS) || (in_rx_byte == CH_DEL);
  assign is_print = (in_rx_byte >= CH_SPACE) && (in_rx_byte <= CH_TILDE);
  assign fill_ext = LIMIT_W'(fill_count_r);
  assign do_store = is_print && (fill_ext < cap);
  assign do_erase = is_bs && (fill_count_r != '0);

  always_comb begin
    fill_after = fill_count_r;
    if (do_store) begin
      fill_after = fill_count_r + 1'b1;
    end else if (do_erase) begin
      fill_after = fill_count_r - 1'b1;
    end
  end

  assign after_ext = LIMIT_W'(fill_after);
  assign end_line  = is_eol || (after_ext >= cap);

  // Command to the back end
  always_comb begin
    q_cmd.echo     = do_store ? ECHO_CHAR : (do_erase ? ECHO_BS : ECHO_NONE);
    q_cmd.ch       = in_rx_byte;
    q_cmd.waddr    = IDX_W'(fill_count_r);
    q_cmd.end_line = end_line;
    q_cmd.len      = IDX_W'(fill_after);
  end

  assign q_push         = in_fire && (do_store || do_erase || end_line);
  assign fill_count_nxt = in_fire ? (end_line ? '0 : fill_after) : fill_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
    end else begin
      fill_count_r <= fill_count_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= FW'(LINE_DEPTH - 1))
    else $error("fill count beyond store depth");

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_eol) |=> (fill_count_r == '0))
    else $error("fill count not cleared at line end");

endmodule

@@ hw/rtl/lef_back.sv @@
`timescale 1ns / 1ps

module lef_back #(
  parameter int LINE_DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  lef_pkg::cmd_t             q_cmd,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_byte,
  output logic [lef_pkg::LEN_W-1:0] out_line_length,
  output logic                      out_last
);
  import lef_pkg::*;

  localparam int FW = $clog2(LINE_DEPTH);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ECHO = 4'd1;
  localparam logic [3:0] ST_BS0  = 4'd2;
  localparam logic [3:0] ST_BS1  = 4'd3;
  localparam logic [3:0] ST_BS2  = 4'd4;
  localparam logic [3:0] ST_LF   = 4'd5;
  localparam logic [3:0] ST_CR   = 4'd6;
  localparam logic [3:0] ST_LINE = 4'd7;
  localparam logic [3:0] ST_MARK = 4'd8;

  logic [3:0]       state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [FW-1:0]    idx_r, idx_nxt;
  logic [FW-1:0]    len;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;
  logic             out_last_r, out_last_nxt;
  logic             slot_free, load;
  logic             ram_we, ram_re;
  logic [FW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  assign len       = cmd_r.len[FW-1:0];
  assign slot_free = !out_valid_r || !out_stall;

  // Line store, written as echoes are carried out
  lef_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (cmd_r.waddr[FW-1:0]),
    .wdata   (cmd_r.ch),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // Result sequencer
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    idx_nxt      = idx_r;
    q_pop        = 1'b0;
    load         = 1'b0;
    out_kind_nxt = KIND_ECHO;
    out_byte_nxt = CH_BS;
    out_len_nxt  = '0;
    out_last_nxt = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.echo == ECHO_CHAR) begin
            state_nxt = ST_ECHO;
          end else if (q_cmd.echo == ECHO_BS) begin
            state_nxt = ST_BS0;
          end else begin
            state_nxt = ST_LF;
          end
        end
      end
      ST_ECHO: begin
        if (slot_free) begin
          load         = 1'b1;
          out_byte_nxt = cmd_r.ch;
          out_last_nxt = !cmd_r.end_line;
          ram_we       = 1'b1;
          state_nxt    = cmd_r.end_line ? ST_LF : ST_IDLE;
        end
      end
      ST_BS0: begin
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = ST_BS1;
        end
      end
      ST_BS1: begin
        if (slot_free) begin
          load         = 1'b1;
          out_byte_nxt = CH_SPACE;
          state_nxt    = ST_BS2;
        end
      end
      ST_BS2: begin
        if (slot_free) begin
          load         = 1'b1;
          out_last_nxt = !cmd_r.end_line;
          state_nxt    = cmd_r.end_line ? ST_LF : ST_IDLE;
        end
      end
      ST_LF: begin
        if (slot_free) begin
          load         = 1'b1;
          out_byte_nxt = CH_LF;
          state_nxt    = ST_CR;
        end
      end
      ST_CR: begin
        if (slot_free) begin
          load         = 1'b1;
          out_byte_nxt = CH_CR;
          // prefetch the first stored byte
          if (len != '0) begin
            ram_re    = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_LINE;
          end else begin
            state_nxt = ST_MARK;
          end
        end
      end
      ST_LINE: begin
        if (slot_free) begin
          load         = 1'b1;
          out_kind_nxt = KIND_LINE;
          out_byte_nxt = ram_rdata;
          if (idx_r == len - 1'b1) begin
            state_nxt = ST_MARK;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r + 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      ST_MARK: begin
        if (slot_free) begin
          load         = 1'b1;
          out_kind_nxt = KIND_END;
          out_byte_nxt = '0;
          out_len_nxt  = LEN_W'(len);
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    if (load) begin
      out_kind_r <= out_kind_nxt;
      out_byte_r <= out_byte_nxt;
      out_len_r  <= out_len_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_byte        = out_byte_r;
  assign out_line_length = out_len_r;
  assign out_last        = out_last_r;

  a_idx_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINE) |-> (idx_r < len))
    else $error("line index past line length");

  a_mark_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_END) |-> out_last_r)
    else $error("end marker not flagged last");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE))
    else $error("command taken while busy");

  a_no_load_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !load)
    else $error("result overwritten while stalled");

endmodule
